/* design/bmao_pkg.sv */
// ----------------------------------------------------------------------------
// bmao_pkg
// Shared types and constants for the battery monitor with auto power off.
// ----------------------------------------------------------------------------
package bmao_pkg;

    localparam int SenseW   = 12;
    localparam int MvW      = 13;
    localparam int PctW     = 7;
    localparam int CauseW   = 2;
    localparam int SecsW    = 14;
    localparam int MinutesW = 8;
    localparam int CfgDataW = 8;

    localparam logic FUNC_TICK     = 1'b0;
    localparam logic FUNC_ACTIVITY = 1'b1;

    localparam logic [CauseW-1:0] CAUSE_NONE     = 2'd0;
    localparam logic [CauseW-1:0] CAUSE_DEAD     = 2'd1;
    localparam logic [CauseW-1:0] CAUSE_AUTO_OFF = 2'd2;

    typedef enum logic [0:0] {
        CFG_AUTO_OFF_MINUTES   = 1'b0,
        CFG_LOW_BATT_SHUTDOWN  = 1'b1
    } bmao_cfg_index_t;

    // sense * 69 / 41 == (sense * MvRecip) >> MvShift for all 12-bit sense
    localparam int               MvShift  = 24;
    localparam logic [24:0]      MvRecip  = 25'd28234869;
    // 100 * d / 830 == (d * PctRecip) >> PctShift for d <= 830
    localparam int               PctShift = 20;
    localparam logic [16:0]      PctRecip = 17'd126340;

    localparam logic [MvW-1:0]   FullMv   = 13'd4080;
    localparam logic [MvW-1:0]   EmptyMv  = 13'd3250;
    localparam logic [MvW-1:0]   DeadMv   = 13'd3200;
    localparam logic [PctW-1:0]  MaxPct   = 7'd100;
    localparam logic [PctW:0]    HystPct  = 8'd2;
    localparam logic [5:0]       SecsPerMin = 6'd60;
    localparam logic [SecsW-1:0] WarnSecs = 14'd10;

    typedef struct packed {
        logic              func;
        logic [SenseW-1:0] sense_mv;
        logic              charging;
        logic              timer_running;
    } bmao_item_t;

    typedef struct packed {
        logic [MvW-1:0]    battery_mv;
        logic [PctW-1:0]   battery_percent;
        logic [CauseW-1:0] shutdown_cause;
        logic              warn_beep;
        logic              alert_show;
        logic              alert_close;
        logic [SecsW-1:0]  seconds_left;
    } bmao_result_t;

endpackage

/* design/battery_monitor_auto_off.sv */
// ----------------------------------------------------------------------------
// battery_monitor_auto_off
// Battery voltage and percent monitor with inactivity auto power off.
// ----------------------------------------------------------------------------
// Items arrive on the item channel (item_valid / item_stall): one-second ticks
// carrying the sense voltage and status, or user-activity events. Every item
// produces exactly one transaction on the result channel (result_valid /
// result_stall) carrying battery mV, percent, shutdown cause, beep and alert
// controls and the seconds left before auto-off.
// An accepted item passes the input and middle registers into the output
// register. Throughput: one item per cycle while result_stall is low, set by
// the three-register pipeline (input register, voltage scaling multiplier,
// percent multiplier plus state update); the monitor state is read and written
// only in the last stage, so items follow each other with no gap.
// When the receiver stalls, the output register holds its transaction and the
// earlier stages keep filling until all three are full; only then is
// item_stall raised.
// Configuration writes on the cfg channel are always ready and take effect
// at once; they are meant to be issued while the block is idle.
// Reset clears the pipeline, the idle counter, the alert flag, the stored
// voltage and percent, sets auto_off_minutes to 0 and enables dead-battery
// shutdown.
// ----------------------------------------------------------------------------
module battery_monitor_auto_off (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  bmao_pkg::bmao_item_t  item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output bmao_pkg::bmao_result_t result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  bmao_pkg::bmao_cfg_index_t cfg_index,
    input  logic [bmao_pkg::CfgDataW-1:0] cfg_data
);
    import bmao_pkg::*;

    logic                  auto_off_en;
    logic [MinutesW-1:0]   minutes_reg;
    logic                  shutdown_en_reg;

    logic                  a_valid_reg;
    bmao_item_t            a_item_reg;

    logic                  b_valid_reg;
    logic [MvW-1:0]        b_mv_reg;
    logic                  b_func_reg;
    logic                  b_charging_reg;
    logic                  b_timer_reg;

    logic                  result_valid_reg;
    bmao_result_t          result_reg;

    logic [SecsW-1:0]      idle_reg;
    logic [PctW-1:0]       last_pct_reg;
    logic                  alert_open_reg;
    logic [MvW-1:0]        last_mv_reg;

    logic                  free_a, free_b, free_c;
    logic                  take_b, take_c;

    logic [36:0]           mv_prod;
    logic [MvW-1:0]        mv_next;

    logic [9:0]            pct_diff;
    logic [26:0]           pct_prod;
    logic [PctW-1:0]       pct_raw;
    logic [PctW-1:0]       pct_hyst;
    logic [PctW:0]         pct_ext;
    logic [PctW:0]         last_ext;
    logic [SecsW-1:0]      limit;
    logic [SecsW-1:0]      idle_inc;
    logic [SecsW-1:0]      idle_next;
    logic                  alert_open_next;
    logic [PctW-1:0]       last_pct_next;
    logic [MvW-1:0]        last_mv_next;
    bmao_result_t          result_next;

    assign auto_off_en = |minutes_reg;

    // pipeline flow control
    assign free_c     = !result_valid_reg || !result_stall;
    assign take_c     = b_valid_reg && free_c;
    assign free_b     = !b_valid_reg || take_c;
    assign take_b     = a_valid_reg && free_b;
    assign free_a     = !a_valid_reg || take_b;
    assign item_stall = !free_a;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    // stage B: battery mV
    assign mv_prod = {25'd0, a_item_reg.sense_mv} * {12'd0, MvRecip};
    assign mv_next = mv_prod[MvShift +: MvW];

    // stage C: percent, hysteresis, auto-off counter
    assign limit    = {6'd0, minutes_reg} * {8'd0, SecsPerMin};
    assign pct_diff = 10'(b_mv_reg - EmptyMv);
    assign pct_prod = {17'd0, pct_diff} * {10'd0, PctRecip};

    always_comb
    begin
        if (b_mv_reg < EmptyMv)
            pct_raw = '0;
        else if (b_mv_reg > FullMv)
            pct_raw = MaxPct;
        else
            pct_raw = pct_prod[PctShift +: PctW];

        pct_ext  = {1'b0, pct_raw};
        last_ext = {1'b0, last_pct_reg};
        pct_hyst = pct_raw;
        if (b_charging_reg)
        begin
            if (pct_ext < last_ext && pct_ext + HystPct >= last_ext)
                pct_hyst = last_pct_reg;
        end
        else
        begin
            if (pct_ext > last_ext && pct_ext <= last_ext + HystPct)
                pct_hyst = last_pct_reg;
        end
    end

    assign idle_inc = (idle_reg == '1) ? idle_reg : idle_reg + 1'b1;

    always_comb
    begin
        idle_next       = idle_reg;
        alert_open_next = alert_open_reg;
        last_pct_next   = last_pct_reg;
        last_mv_next    = last_mv_reg;
        result_next     = '0;

        if (b_func_reg == FUNC_ACTIVITY)
        begin
            idle_next               = '0;
            result_next.alert_close = alert_open_reg;
            alert_open_next         = 1'b0;
        end
        else
        begin
            last_pct_next = pct_hyst;
            last_mv_next  = b_mv_reg;
            if (b_mv_reg <= DeadMv)
            begin
                if (shutdown_en_reg)
                    result_next.shutdown_cause = CAUSE_DEAD;
            end
            else if (auto_off_en && !b_timer_reg)
            begin
                idle_next = idle_inc;
                if (idle_inc >= limit)
                begin
                    result_next.shutdown_cause = CAUSE_AUTO_OFF;
                    result_next.alert_close    = 1'b1;
                    alert_open_next            = 1'b0;
                end
                else if (idle_inc >= limit - WarnSecs)
                begin
                    result_next.warn_beep = 1'b1;
                    if (idle_inc == limit - WarnSecs && !alert_open_reg)
                    begin
                        result_next.alert_show = 1'b1;
                        alert_open_next        = 1'b1;
                    end
                end
            end
        end

        result_next.battery_mv      = last_mv_next;
        result_next.battery_percent = last_pct_next;
        result_next.seconds_left    = (idle_next >= limit) ? '0 : limit - idle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minutes_reg      <= '0;
            shutdown_en_reg  <= 1'b1;
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            idle_reg         <= '0;
            last_pct_reg     <= '0;
            alert_open_reg   <= 1'b0;
            last_mv_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_AUTO_OFF_MINUTES:  minutes_reg     <= cfg_data[MinutesW-1:0];
                    CFG_LOW_BATT_SHUTDOWN: shutdown_en_reg <= cfg_data[0];
                    default:               ;
                endcase
            end
            if (free_a)
                a_valid_reg <= item_valid;
            if (free_b)
                b_valid_reg <= a_valid_reg;
            if (free_c)
                result_valid_reg <= b_valid_reg;
            if (take_c)
            begin
                idle_reg       <= idle_next;
                last_pct_reg   <= last_pct_next;
                alert_open_reg <= alert_open_next;
                last_mv_reg    <= last_mv_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_a)
            a_item_reg <= item;
        if (free_b)
        begin
            b_mv_reg       <= mv_next;
            b_func_reg     <= a_item_reg.func;
            b_charging_reg <= a_item_reg.charging;
            b_timer_reg    <= a_item_reg.timer_running;
        end
        if (take_c)
            result_reg <= result_next;
    end

endmodule

/* design/bmao_checker.sv */
// ----------------------------------------------------------------------------
// bmao_checker
// Port-level assertions for the battery monitor, bound to the top level.
// ----------------------------------------------------------------------------
module bmao_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       result_valid,
    input logic                       result_stall,
    input bmao_pkg::bmao_result_t     result
);
    import bmao_pkg::*;

    // stalled transaction holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_cause_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.shutdown_cause != 2'd3)
        else $error("illegal shutdown cause");

    a_show_close: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.alert_show && result.alert_close))
        else $error("alert opened and closed together");

    a_show_beep: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.alert_show |-> result.warn_beep
            && result.shutdown_cause == CAUSE_NONE)
        else $error("alert opened outside warning window");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.battery_percent <= MaxPct)
        else $error("percent out of range");

endmodule

bind battery_monitor_auto_off bmao_checker u_bmao_checker (.*);
